[src/dlq_pkg.sv]
`default_nettype none
package dlq_pkg;

	localparam int ENTRIES     = 64;
	localparam int HANDLE_BITS = 8;
	localparam int DELAY_BITS  = 32;

	// result kinds
	localparam logic [2:0] KIND_QUEUED  = 3'd0;
	localparam logic [2:0] KIND_FIRED   = 3'd1;
	localparam logic [2:0] KIND_FULL    = 3'd2;
	localparam logic [2:0] KIND_IGNORED = 3'd3;
	localparam logic [2:0] KIND_EXPIRED = 3'd4;
	localparam logic [2:0] KIND_NONE    = 3'd5;

	// token modes
	localparam logic TOK_WALK  = 1'b0;
	localparam logic TOK_SHIFT = 1'b1;

	// insertion token passed from cell to cell
	typedef struct packed {
		logic                   v;
		logic                   mode;
		logic [DELAY_BITS-1:0]  delay;
		logic [HANDLE_BITS-1:0] hdl;
	} tok_t;

	// commands broadcast to the cells
	typedef struct packed {
		logic pop;
		logic dec;
	} cell_cmd_t;

endpackage
`default_nettype wire

[src/dlq_cell.sv]
`default_nettype none
module dlq_cell import dlq_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cell_cmd_t              cmd,
	input  wire tok_t                   tok_in,
	output tok_t                        tok_out,
	input  wire logic                   nb_vld,
	input  wire logic [DELAY_BITS-1:0]  nb_dly,
	input  wire logic [HANDLE_BITS-1:0] nb_hdl,
	output logic                        vld,
	output logic [DELAY_BITS-1:0]       dly,
	output logic [HANDLE_BITS-1:0]      hdl
);

	logic                   vld_q;
	logic [DELAY_BITS-1:0]  dly_q;
	logic [HANDLE_BITS-1:0] hdl_q;
	logic                   tok_v_q;
	logic                   tok_mode_q;
	logic [DELAY_BITS-1:0]  tok_dly_q;
	logic [HANDLE_BITS-1:0] tok_hdl_q;
	logic                   pass;

	assign vld     = vld_q;
	assign dly     = dly_q;
	assign hdl     = hdl_q;
	assign tok_out = '{v: tok_v_q, mode: tok_mode_q, delay: tok_dly_q, hdl: tok_hdl_q};

	// new timer still later than this entry: walk on
	assign pass = (tok_in.mode == TOK_WALK) && vld_q && (tok_in.delay > dly_q);

	// valid bit and outgoing token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			tok_v_q <= 1'b0;
		end else begin
			tok_v_q <= 1'b0;
			if (cmd.pop) begin
				vld_q <= nb_vld;
			end else if (tok_in.v) begin
				if (pass) begin
					tok_v_q <= 1'b1;
				end else begin
					vld_q   <= 1'b1;
					tok_v_q <= vld_q;
				end
			end
		end
	end

	// entry contents and token payload
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			dly_q <= nb_dly;
			hdl_q <= nb_hdl;
		end else if (cmd.dec) begin
			if (vld_q && dly_q != '0) begin
				dly_q <= dly_q - 1'b1;
			end
		end else if (tok_in.v) begin
			if (pass) begin
				tok_mode_q <= TOK_WALK;
				tok_dly_q  <= tok_in.delay - dly_q;
				tok_hdl_q  <= tok_in.hdl;
			end else begin
				dly_q      <= tok_in.delay;
				hdl_q      <= tok_in.hdl;
				tok_mode_q <= TOK_SHIFT;
				tok_hdl_q  <= hdl_q;
				if (tok_in.mode == TOK_WALK) begin
					tok_dly_q <= dly_q - tok_in.delay;
				end else begin
					tok_dly_q <= dly_q;
				end
			end
		end
	end

endmodule
`default_nettype wire

[src/delta_list_timer_queue.sv]
// an add gives its registered result in the cycle after it is taken
// a tick on an empty list answers in the cycle after it is taken; otherwise it
// enters ST_POP and then gives one expired timer per cycle while out_stall is low
// an add that queues keeps the input stalled while its token walks and shifts
// through the occupied cells; a tick holds it until its last result (there is at
// least one) is given, plus any output stall
// reset: arst_n asynchronously empties every cell, no clearing pass
`default_nettype none
module delta_list_timer_queue import dlq_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  req_type,
	input  wire logic [DELAY_BITS-1:0] delay_ticks,
	input  wire logic [7:0]            handle,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [2:0]                 kind,
	output logic [7:0]                 fired_handle,
	output logic                       last
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_POP  = 1'b1;

	logic                   state_q;
	logic                   out_valid_q;
	logic [2:0]             kind_q;
	logic [HANDLE_BITS-1:0] hdl_q;
	logic                   last_q;

	tok_t                   tok [ENTRIES+1];
	cell_cmd_t              cmd [ENTRIES];
	logic [ENTRIES-1:0]     cvld;
	logic [DELAY_BITS-1:0]  cdly [ENTRIES];
	logic [HANDLE_BITS-1:0] chdl [ENTRIES];

	logic                   busy;
	logic                   out_free;
	logic                   acc;
	logic [HANDLE_BITS-1:0] hin;
	logic                   exp0;
	logic                   exp1;
	logic                   pop;

	assign hin      = handle[HANDLE_BITS-1:0];
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || busy || !out_free;
	assign acc      = in_valid && !in_stall;
	assign exp0     = cvld[0] && (cdly[0] == '0);
	assign exp1     = cvld[1] && (cdly[1] == '0);
	assign pop      = (state_q == ST_POP) && out_free && exp0;

	// any insertion token still in flight
	always_comb begin
		busy = 1'b0;
		for (int i = 1; i <= ENTRIES; i++) begin
			busy = busy | tok[i].v;
		end
	end

	// token injected at the head of the row
	always_comb begin
		tok[0].v     = acc && !req_type && (hin != '0) && (delay_ticks != '0)
			&& !cvld[ENTRIES-1];
		tok[0].mode  = TOK_WALK;
		tok[0].delay = delay_ticks;
		tok[0].hdl   = hin;
	end

	// row of cells
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic                   nb_vld;
		logic [DELAY_BITS-1:0]  nb_dly;
		logic [HANDLE_BITS-1:0] nb_hdl;

		if (i == ENTRIES - 1) begin : g_end
			assign nb_vld = 1'b0;
			assign nb_dly = '0;
			assign nb_hdl = '0;
		end else begin : g_mid
			assign nb_vld = cvld[i+1];
			assign nb_dly = cdly[i+1];
			assign nb_hdl = chdl[i+1];
		end

		assign cmd[i].pop = pop;
		if (i == 0) begin : g_head
			assign cmd[i].dec = acc && req_type;
		end else begin : g_tail
			assign cmd[i].dec = 1'b0;
		end

		dlq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd[i]),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.nb_vld  (nb_vld),
			.nb_dly  (nb_dly),
			.nb_hdl  (nb_hdl),
			.vld     (cvld[i]),
			.dly     (cdly[i]),
			.hdl     (chdl[i])
		);
	end

	// control: state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				if (req_type && cvld[0]) begin
					state_q     <= ST_POP;
					out_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if ((state_q == ST_POP) && out_free) begin
				out_valid_q <= 1'b1;
				if (!exp0 || !exp1) begin
					state_q <= ST_IDLE;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			hdl_q  <= '0;
			last_q <= 1'b1;
			if (req_type) begin
				kind_q <= KIND_NONE;
			end else if (hin == '0) begin
				kind_q <= KIND_IGNORED;
			end else if (delay_ticks == '0) begin
				kind_q <= KIND_FIRED;
				hdl_q  <= hin;
			end else if (cvld[ENTRIES-1]) begin
				kind_q <= KIND_FULL;
			end else begin
				kind_q <= KIND_QUEUED;
			end
		end else if ((state_q == ST_POP) && out_free) begin
			if (exp0) begin
				kind_q <= KIND_EXPIRED;
				hdl_q  <= chdl[0];
				last_q <= !exp1;
			end else begin
				kind_q <= KIND_NONE;
				hdl_q  <= '0;
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign fired_handle = hdl_q;
	assign last         = last_q;

	// occupied cells always form a prefix of the row
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((cvld + 1'b1) & cvld) == '0)
		else $error("cell row has a gap");

	// tokens only travel while no tick is being worked
	a_tok_idle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> state_q == ST_IDLE)
		else $error("insertion token during tick");

	// a tick on a non-empty list moves on to popping
	a_tick_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req_type && cvld[0]) |=> state_q == ST_POP)
		else $error("tick did not start popping");

	// only heads with zero delta are removed
	a_pop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (cvld[0] && cdly[0] == '0))
		else $error("pop of a live head");

endmodule
`default_nettype wire
